### hdl/srsw_pkg.sv
// Shared constants and types for the selective-repeat sender window block.
`default_nettype none

package srsw_pkg;

    // Slot count of the window store; kept a power of two so the slot index is a bit slice.
    localparam int MAX_WINDOW = 16;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);

    localparam int SEQ_W  = 32;
    localparam int TICK_W = 32;
    localparam int WIN_W  = 5;
    localparam int TOT_W  = 20;
    localparam int TMO_W  = 24;
    localparam int SID_W  = 32;
    localparam int CMD_W  = 2;
    localparam int ATYP_W = 4;
    localparam int PTYP_W = 2;
    localparam int PH_W   = 3;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
    localparam logic [1:0] REG_TOTAL_PACKETS = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;
    localparam logic [1:0] REG_SESSION_ID    = 2'd3;

    localparam logic [WIN_W-1:0] WINDOW_SIZE_RST   = WIN_W'(4);
    localparam logic [TOT_W-1:0] TOTAL_PACKETS_RST = '0;
    localparam logic [TMO_W-1:0] TIMEOUT_TICKS_RST = TMO_W'(500);
    localparam logic [SID_W-1:0] SESSION_ID_RST    = '0;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd2;

    // Packet types
    localparam logic [PTYP_W-1:0] PKT_START = 2'd0;
    localparam logic [PTYP_W-1:0] PKT_END   = 2'd1;
    localparam logic [PTYP_W-1:0] PKT_DATA  = 2'd2;

    localparam logic [ATYP_W-1:0] ACK_TYPE = 4'd3;

    typedef enum logic [PH_W-1:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_DATA  = 3'd2,
        PH_END   = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

endpackage

`default_nettype wire

### hdl/srsw_if.sv
// Valid/ready channel interfaces for the command input and the packet output.
`default_nettype none

interface srsw_in_if;
    import srsw_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ATYP_W-1:0] ack_type;
    logic [SEQ_W-1:0]  ack_seq;
    logic [SEQ_W-1:0]  ack_checksum;

    modport source (output valid, command, ack_type, ack_seq, ack_checksum, input ready);
    modport sink   (input valid, command, ack_type, ack_seq, ack_checksum, output ready);
endinterface

interface srsw_out_if;
    import srsw_pkg::*;

    logic              valid;
    logic              ready;
    logic [PTYP_W-1:0] send_type;
    logic [SEQ_W-1:0]  send_seq;
    logic              last_of_run;
    logic [PH_W-1:0]   phase;

    modport source (output valid, send_type, send_seq, last_of_run, phase, input ready);
    modport sink   (input valid, send_type, send_seq, last_of_run, phase, output ready);
endinterface

`default_nettype wire

### hdl/selective_repeat_sender_window_core.sv
// Selective-repeat sender window control: handshake phases, window scan and slide.
//
//  channel | dir | transfer when      | payload
//  --------+-----+--------------------+------------------------------------------
//  req     | in  | valid && ready     | command, ack_type, ack_seq, ack_checksum
//  snd     | out | valid && ready     | send_type, send_seq, last_of_run, phase
//  apb     | in  | psel&penable&pwrite| paddr[3:2] selects register, pwdata
//
//  One command at a time. A tick in the data phase scans the window slot by slot. A data
//  ack marks its slot, slides the base over acked slots when it acks the base, then scans.
//  The slot scan walks the window through one shared timeout subtract/compare.
//  Reset clears phase, counters and per-slot flags; no clearing pass is needed.
//  A stalled output blocks the scan only when a second packet is ready to go.
`default_nettype none

module selective_repeat_sender_window_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    srsw_in_if.sink                         req,
    srsw_out_if.source                      snd,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [srsw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [srsw_pkg::DATA_W-1:0] pwdata,
    output logic      [srsw_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import srsw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_ACK,
        S_ACK_RANGE,
        S_SLIDE,
        S_SCAN_INIT,
        S_SCAN,
        S_FIN
    } state_t;

    // ---------------- configuration ----------------
    logic [WIN_W-1:0] window_size_reg;
    logic [TOT_W-1:0] total_packets_reg;
    logic [TMO_W-1:0] timeout_ticks_reg;
    logic [SID_W-1:0] session_id_reg;

    logic cfg_we;
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg   <= WINDOW_SIZE_RST;
            total_packets_reg <= TOTAL_PACKETS_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
            session_id_reg    <= SESSION_ID_RST;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_WINDOW_SIZE:   window_size_reg   <= pwdata[WIN_W-1:0];
                REG_TOTAL_PACKETS: total_packets_reg <= pwdata[TOT_W-1:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata[TMO_W-1:0];
                REG_SESSION_ID:    session_id_reg    <= pwdata[SID_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WINDOW_SIZE:   prdata = DATA_W'(window_size_reg);
            REG_TOTAL_PACKETS: prdata = DATA_W'(total_packets_reg);
            REG_TIMEOUT_TICKS: prdata = DATA_W'(timeout_ticks_reg);
            REG_SESSION_ID:    prdata = DATA_W'(session_id_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- state ----------------
    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [TICK_W-1:0]    hs_at_reg, hs_at_next;
    logic [TOT_W-1:0]     base_reg, base_next;
    logic [TOT_W-1:0]     scan_reg, scan_next;
    logic [TOT_W-1:0]     wend_reg, wend_next;
    logic [MAX_WINDOW-1:0] acked_reg, acked_next;
    logic [MAX_WINDOW-1:0] ever_reg, ever_next;
    logic [TICK_W-1:0]    sent_at_mem [MAX_WINDOW];

    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [ATYP_W-1:0]    atype_reg, atype_next;
    logic [SEQ_W-1:0]     aseq_reg, aseq_next;
    logic [SEQ_W-1:0]     acks_reg, acks_next;

    // one-deep hold: the newest packet waits here until it is known to be last or not
    logic                 hold_valid_reg, hold_valid_next;
    logic [PTYP_W-1:0]    hold_type_reg, hold_type_next;
    logic [SEQ_W-1:0]     hold_seq_reg, hold_seq_next;
    phase_t               hold_phase_reg, hold_phase_next;

    logic                 out_valid_reg, out_valid_next;
    logic [PTYP_W-1:0]    out_type_reg, out_type_next;
    logic [SEQ_W-1:0]     out_seq_reg, out_seq_next;
    logic                 out_last_reg, out_last_next;
    phase_t               out_phase_reg, out_phase_next;

    logic                 sent_we;
    logic [SLOT_W-1:0]    sent_idx;

    // ---------------- datapath helpers ----------------
    logic [WIN_W-1:0]  eff_win;
    logic [TOT_W:0]    win_sum;
    logic [TOT_W-1:0]  wend_calc;
    logic [SLOT_W-1:0] scan_slot;
    logic [TICK_W-1:0] cmp_ref;
    logic              timed_out;
    logic              hdr_ok;
    logic              out_free;
    logic              can_push;
    logic              emit;
    logic [PTYP_W-1:0] emit_type;
    logic [SEQ_W-1:0]  emit_seq;

    always_comb
    begin
        if (window_size_reg == '0)
            eff_win = WIN_W'(1);
        else if (window_size_reg > WIN_W'(MAX_WINDOW))
            eff_win = WIN_W'(MAX_WINDOW);
        else
            eff_win = window_size_reg;
    end

    assign win_sum   = {1'b0, base_reg} + (TOT_W+1)'(eff_win);
    assign wend_calc = (win_sum < {1'b0, total_packets_reg}) ? win_sum[TOT_W-1:0]
                                                             : total_packets_reg;
    assign scan_slot = scan_reg[SLOT_W-1:0];

    // shared elapsed-time compare: handshake time or the scanned slot's send time
    assign cmp_ref   = (state_reg == S_SCAN) ? sent_at_mem[scan_slot] : hs_at_reg;
    assign timed_out = (tick_reg - cmp_ref) >= TICK_W'(timeout_ticks_reg);

    assign hdr_ok    = (acks_reg == '0) && (atype_reg == ACK_TYPE);
    assign out_free  = !out_valid_reg || snd.ready;
    assign can_push  = !hold_valid_reg || out_free;

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        hs_at_next      = hs_at_reg;
        base_next       = base_reg;
        scan_next       = scan_reg;
        wend_next       = wend_reg;
        acked_next      = acked_reg;
        ever_next       = ever_reg;
        cmd_next        = cmd_reg;
        atype_next      = atype_reg;
        aseq_next       = aseq_reg;
        acks_next       = acks_reg;
        hold_valid_next = hold_valid_reg;
        hold_type_next  = hold_type_reg;
        hold_seq_next   = hold_seq_reg;
        hold_phase_next = hold_phase_reg;
        out_valid_next  = out_valid_reg;
        out_type_next   = out_type_reg;
        out_seq_next    = out_seq_reg;
        out_last_next   = out_last_reg;
        out_phase_next  = out_phase_reg;
        sent_we         = 1'b0;
        sent_idx        = scan_slot;
        emit            = 1'b0;
        emit_type       = PKT_DATA;
        emit_seq        = SEQ_W'(scan_reg);

        if (out_valid_reg && snd.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.command;
                    atype_next = req.ack_type;
                    aseq_next  = req.ack_seq;
                    acks_next  = req.ack_checksum;
                    state_next = S_FIN;
                    if (req.command == CMD_TICK)
                    begin
                        tick_next  = tick_reg + 1'b1;
                        state_next = S_TICK;
                    end
                    else if (req.command == CMD_ACK)
                    begin
                        state_next = S_ACK;
                    end
                    else if (req.command == CMD_BEGIN &&
                             (phase_reg == PH_IDLE || phase_reg == PH_DONE))
                    begin
                        // hold is always empty here, so the start packet goes straight in
                        base_next  = '0;
                        acked_next = '0;
                        ever_next  = '0;
                        phase_next = PH_START;
                        hs_at_next = tick_reg;
                        emit       = 1'b1;
                        emit_type  = PKT_START;
                        emit_seq   = session_id_reg;
                    end
                end
            end

            S_TICK:
            begin
                if (phase_reg == PH_START || phase_reg == PH_END)
                begin
                    if (!timed_out)
                        state_next = S_FIN;
                    else if (can_push)
                    begin
                        hs_at_next = tick_reg;
                        emit       = 1'b1;
                        emit_type  = (phase_reg == PH_START) ? PKT_START : PKT_END;
                        emit_seq   = session_id_reg;
                        state_next = S_FIN;
                    end
                end
                else if (phase_reg == PH_DATA)
                    state_next = S_SCAN_INIT;
                else
                    state_next = S_FIN;
            end

            S_ACK:
            begin
                state_next = S_FIN;
                if (hdr_ok && aseq_reg == session_id_reg)
                begin
                    if (phase_reg == PH_START)
                    begin
                        phase_next = PH_DATA;
                        state_next = S_SCAN_INIT;
                    end
                    else if (phase_reg == PH_END)
                        phase_next = PH_DONE;
                end
                else if (hdr_ok && phase_reg == PH_DATA)
                    state_next = S_ACK_RANGE;
            end

            S_ACK_RANGE:
            begin
                if (aseq_reg >= SEQ_W'(base_reg) && aseq_reg < SEQ_W'(wend_calc))
                begin
                    acked_next[aseq_reg[SLOT_W-1:0]] = 1'b1;
                    state_next = (aseq_reg == SEQ_W'(base_reg)) ? S_SLIDE : S_SCAN_INIT;
                end
                else
                    state_next = S_FIN;
            end

            S_SLIDE:
            begin
                // acked slots all lie within one window span, so this stops by itself
                if (base_reg < total_packets_reg && acked_reg[base_reg[SLOT_W-1:0]])
                begin
                    acked_next[base_reg[SLOT_W-1:0]] = 1'b0;
                    ever_next[base_reg[SLOT_W-1:0]]  = 1'b0;
                    base_next = base_reg + 1'b1;
                end
                else
                    state_next = S_SCAN_INIT;
            end

            S_SCAN_INIT:
            begin
                if (base_reg >= total_packets_reg)
                begin
                    if (can_push)
                    begin
                        phase_next = PH_END;
                        hs_at_next = tick_reg;
                        emit       = 1'b1;
                        emit_type  = PKT_END;
                        emit_seq   = session_id_reg;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    scan_next  = base_reg;
                    wend_next  = wend_calc;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (scan_reg < wend_reg)
                begin
                    if (!acked_reg[scan_slot] && (!ever_reg[scan_slot] || timed_out))
                    begin
                        if (can_push)
                        begin
                            ever_next[scan_slot] = 1'b1;
                            sent_we   = 1'b1;
                            emit      = 1'b1;
                            scan_next = scan_reg + 1'b1;
                        end
                    end
                    else
                        scan_next = scan_reg + 1'b1;
                end
                else
                    state_next = S_FIN;
            end

            S_FIN:
            begin
                if (!hold_valid_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_type_next   = hold_type_reg;
                    out_seq_next    = hold_seq_reg;
                    out_phase_next  = hold_phase_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // a new packet pushes the held one out as not-last
        if (emit)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_type_next  = hold_type_reg;
                out_seq_next   = hold_seq_reg;
                out_phase_next = hold_phase_reg;
                out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_type_next  = emit_type;
            hold_seq_next   = emit_seq;
            hold_phase_next = phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            hs_at_reg      <= '0;
            base_reg       <= '0;
            acked_reg      <= '0;
            ever_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            hs_at_reg      <= hs_at_next;
            base_reg       <= base_next;
            acked_reg      <= acked_next;
            ever_reg       <= ever_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        wend_reg       <= wend_next;
        cmd_reg        <= cmd_next;
        atype_reg      <= atype_next;
        aseq_reg       <= aseq_next;
        acks_reg       <= acks_next;
        hold_type_reg  <= hold_type_next;
        hold_seq_reg   <= hold_seq_next;
        hold_phase_reg <= hold_phase_next;
        out_type_reg   <= out_type_next;
        out_seq_reg    <= out_seq_next;
        out_last_reg   <= out_last_next;
        out_phase_reg  <= out_phase_next;
        if (sent_we)
            sent_at_mem[sent_idx] <= tick_reg;
    end

    assign snd.valid       = out_valid_reg;
    assign snd.send_type   = out_type_reg;
    assign snd.send_seq    = out_seq_reg;
    assign snd.last_of_run = out_last_reg;
    assign snd.phase       = out_phase_reg;

    // ---------------- assertions ----------------
    // a command is fully finished before the next is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("command accepted while previous one still in progress");

    // every run is flushed before going back to idle
    a_hold_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !hold_valid_reg)
        else $error("held packet left behind at end of command");

    // a non-final packet on the output always has a successor waiting
    a_not_last_has_next: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> hold_valid_reg)
        else $error("non-final packet without a following packet");

    // the ignored command code and command register agree on the short path
    a_unknown_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) == S_IDLE && state_reg == S_FIN && cmd_reg != CMD_BEGIN)
        |-> !hold_valid_reg)
        else $error("ignored command produced a packet");

endmodule

`default_nettype wire
